// ----- sv/mfsd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfsd_pkg
// shared types and codes for the frame buffer shape drawer
// ----------------------------------------------------------------------------
package mfsd_pkg;

    typedef enum logic [2:0] {
        ACT_PIXEL = 3'd0,
        ACT_RECT  = 3'd1,
        ACT_BOX   = 3'd2,
        ACT_RING  = 3'd3,
        ACT_DISC  = 3'd4,
        ACT_READ  = 3'd5
    } action_t;

    // request to the pixel writer: one plot at wrapped coordinates
    typedef struct packed {
        logic       valid;
        logic [7:0] x;
        logic [7:0] y;
        logic       color;
    } plot_req_t;

endpackage

// ----- sv/mono_framebuffer_shape_drawer_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mono_framebuffer_shape_drawer_core
// one-bit frame buffer with byte read-back and pixel, rectangle, box, circle and disc drawing
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  in      | in_valid/in_ready  | action pos_x pos_y extent_x extent_y border color
//  out     | out_valid/out_ready| read_byte
//
//  each on-screen pixel is read, modified and written back by the plotter (one
//  ram port), which holds busy meanwhile; an off-screen pixel skips the ram; a
//  read passes S_RDWAIT and S_RDCAP to S_RESP; boxes add S_NEXTR per part,
//  circles and discs S_STEP per midpoint step, discs S_CIRC per span
//  after reset a clearing sweep writes zero to all ROW_BYTES*SCREEN_HEIGHT
//  bytes (1024 by default) with in_ready low
//  one command at a time; in_ready stays low until its response is taken
// ----------------------------------------------------------------------------
module mono_framebuffer_shape_drawer_core #(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] action,
    input  logic [7:0] pos_x,
    input  logic [7:0] pos_y,
    input  logic [7:0] extent_x,
    input  logic [7:0] extent_y,
    input  logic [7:0] border,
    input  logic       color,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] read_byte
);

    // sequencer states
    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_RECT   = 9'b000000010, // walk the current rectangle
        S_NEXTR  = 9'b000000100, // pick next box part
        S_CIRC   = 9'b000001000, // emit the octant points or spans
        S_SPAN   = 9'b000010000, // walk one disc span
        S_STEP   = 9'b000100000, // midpoint update
        S_RDWAIT = 9'b001000000, // ram read latency
        S_RDCAP  = 9'b010000000,
        S_RESP   = 9'b100000000
    } state_t;

    state_t      state_reg, state_next;
    logic [2:0]  act_reg;
    logic [7:0]  x_reg, y_reg, w_reg, h_reg, b_reg;
    logic        color_reg;
    // rectangle walker: origin, size, counters
    logic [7:0]  rx_reg, rx_next, ry_reg, ry_next, rw_reg, rw_next, rh_reg, rh_next;
    logic [7:0]  ci_reg, ci_next, cj_reg, cj_next;
    logic [1:0]  part_reg, part_next;
    // midpoint state, signed and wide enough for radius 255
    logic signed [11:0] ca_reg, ca_next, cb_reg, cb_next;
    logic signed [11:0] da_reg, da_next, db_reg, db_next;
    logic signed [19:0] err_reg, err_next;
    logic [2:0]  pt_reg, pt_next;
    // span walker: start column, remaining count (up to 511)
    logic [7:0]  sx_reg, sx_next, sy_reg, sy_next;
    logic [9:0]  sn_reg, sn_next;
    logic [7:0]  rdb_reg, rdb_next;

    mfsd_pkg::plot_req_t preq;
    logic       p_busy, p_clearing;
    logic [7:0] p_rd;

    logic [7:0] pa, pb;
    logic [7:0] ptx, pty;
    logic [9:0] hl;
    logic [7:0] hv, rowv;

    assign pa = ca_reg[7:0];
    assign pb = cb_reg[7:0];

    // octant point select
    always_comb
    begin
        case (pt_reg)
            3'd0:
            begin
                ptx = x_reg + pa;
                pty = y_reg + pb;
            end
            3'd1:
            begin
                ptx = x_reg + pb;
                pty = y_reg + pa;
            end
            3'd2:
            begin
                ptx = x_reg - pb;
                pty = y_reg + pa;
            end
            3'd3:
            begin
                ptx = x_reg - pa;
                pty = y_reg + pb;
            end
            3'd4:
            begin
                ptx = x_reg - pa;
                pty = y_reg - pb;
            end
            3'd5:
            begin
                ptx = x_reg - pb;
                pty = y_reg - pa;
            end
            3'd6:
            begin
                ptx = x_reg + pb;
                pty = y_reg - pa;
            end
            default:
            begin
                ptx = x_reg + pa;
                pty = y_reg - pb;
            end
        endcase
    end

    // disc span select: half width and row for span pt_reg[1:0]
    always_comb
    begin
        case (pt_reg[1:0])
            2'd0:
            begin
                hv   = pa;
                rowv = y_reg + pb;
            end
            2'd1:
            begin
                hv   = pa;
                rowv = y_reg - pb;
            end
            2'd2:
            begin
                hv   = pb;
                rowv = y_reg + pa;
            end
            default:
            begin
                hv   = pb;
                rowv = y_reg - pa;
            end
        endcase
        hl = {1'b0, hv, 1'b0} + 10'd1;
    end

    always_comb
    begin
        state_next = state_reg;
        rx_next = rx_reg; ry_next = ry_reg; rw_next = rw_reg; rh_next = rh_reg;
        ci_next = ci_reg; cj_next = cj_reg; part_next = part_reg;
        ca_next = ca_reg; cb_next = cb_reg; da_next = da_reg; db_next = db_reg;
        err_next = err_reg; pt_next = pt_reg;
        sx_next = sx_reg; sy_next = sy_reg; sn_next = sn_reg;
        rdb_next = rdb_reg;
        preq = '0;
        preq.color = color_reg;
        case (state_reg)
            S_IDLE:
            begin
                // command capture happens in the register block
            end
            S_RECT:
            begin
                if (!p_busy)
                begin
                    if (ci_reg == rw_reg || rh_reg == 8'd0)
                    begin
                        state_next = (act_reg == mfsd_pkg::ACT_BOX) ? S_NEXTR : S_RESP;
                    end
                    else
                    begin
                        preq.valid = 1'b1;
                        preq.x = rx_reg + ci_reg;
                        preq.y = ry_reg + cj_reg;
                        if (cj_reg == rh_reg - 8'd1)
                        begin
                            cj_next = 8'd0;
                            ci_next = ci_reg + 8'd1;
                        end
                        else
                        begin
                            cj_next = cj_reg + 8'd1;
                        end
                    end
                end
            end
            S_NEXTR:
            begin
                ci_next = 8'd0;
                cj_next = 8'd0;
                part_next = part_reg + 2'd1;
                state_next = S_RECT;
                case (part_reg)
                    2'd0:
                    begin
                        rx_next = x_reg; ry_next = y_reg + h_reg - b_reg;
                        rw_next = w_reg; rh_next = b_reg;
                    end
                    2'd1:
                    begin
                        rx_next = x_reg; ry_next = y_reg;
                        rw_next = b_reg; rh_next = h_reg;
                    end
                    2'd2:
                    begin
                        rx_next = x_reg + w_reg - b_reg; ry_next = y_reg;
                        rw_next = b_reg; rh_next = h_reg;
                    end
                    default:
                    begin
                        state_next = S_RESP;
                    end
                endcase
            end
            S_CIRC:
            begin
                if (ca_reg < cb_reg)
                begin
                    state_next = S_RESP;
                end
                else if (act_reg == mfsd_pkg::ACT_RING)
                begin
                    if (!p_busy)
                    begin
                        preq.valid = 1'b1;
                        preq.x = ptx;
                        preq.y = pty;
                        pt_next = pt_reg + 3'd1;
                        if (pt_reg == 3'd7)
                        begin
                            state_next = S_STEP;
                        end
                    end
                end
                else
                begin
                    sx_next = x_reg - hv;
                    sy_next = rowv;
                    sn_next = hl;
                    state_next = S_SPAN;
                end
            end
            S_SPAN:
            begin
                if (!p_busy)
                begin
                    if (sn_reg == 10'd0)
                    begin
                        pt_next = pt_reg + 3'd1;
                        state_next = (pt_reg[1:0] == 2'd3) ? S_STEP : S_CIRC;
                    end
                    else
                    begin
                        preq.valid = 1'b1;
                        preq.x = sx_reg;
                        preq.y = sy_reg;
                        sx_next = sx_reg + 8'd1;
                        sn_next = sn_reg - 10'd1;
                    end
                end
            end
            S_STEP:
            begin
                pt_next = 3'd0;
                cb_next = cb_reg + 12'sd1;
                db_next = db_reg + 12'sd2;
                if (((err_reg + 20'(db_reg)) <<< 1) + 20'(da_reg) > 20'sd0)
                begin
                    ca_next = ca_reg - 12'sd1;
                    err_next = err_reg + 20'(db_reg) + 20'(da_reg);
                    da_next = da_reg + 12'sd2;
                end
                else
                begin
                    err_next = err_reg + 20'(db_reg);
                end
                state_next = S_CIRC;
            end
            S_RDWAIT:
            begin
                state_next = S_RDCAP;
            end
            S_RDCAP:
            begin
                rdb_next = p_rd;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (state_reg == S_RDWAIT)
        begin
            preq.x = x_reg;
            preq.y = y_reg;
        end
    end

    logic rd_on;
    assign rd_on = (32'(pos_x) < SCREEN_WIDTH) && (32'(pos_y) < SCREEN_HEIGHT);

    // a read addresses the ram from the idle cycle of the request itself
    logic accept;
    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE) && !p_busy;

    mfsd_pkg::plot_req_t preq_mux;
    always_comb
    begin
        preq_mux = preq;
        if (accept && action == mfsd_pkg::ACT_READ)
        begin
            preq_mux.x = pos_x;
            preq_mux.y = pos_y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else if (accept)
        begin
            case (action)
                mfsd_pkg::ACT_PIXEL,
                mfsd_pkg::ACT_RECT,
                mfsd_pkg::ACT_BOX:   state_reg <= S_RECT;
                mfsd_pkg::ACT_RING,
                mfsd_pkg::ACT_DISC:  state_reg <= S_CIRC;
                mfsd_pkg::ACT_READ:  state_reg <= rd_on ? S_RDWAIT : S_RESP;
                default:             state_reg <= S_RESP;
            endcase
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg   <= action;
            x_reg     <= pos_x;
            y_reg     <= pos_y;
            w_reg     <= extent_x;
            h_reg     <= extent_y;
            b_reg     <= border;
            color_reg <= color;
            ci_reg    <= 8'd0;
            cj_reg    <= 8'd0;
            part_reg  <= 2'd0;
            rx_reg    <= pos_x;
            ry_reg    <= pos_y;
            case (action)
                mfsd_pkg::ACT_PIXEL:
                begin
                    rw_reg <= 8'd1; rh_reg <= 8'd1;
                end
                mfsd_pkg::ACT_BOX:
                begin
                    rw_reg <= extent_x; rh_reg <= border;
                end
                default:
                begin
                    rw_reg <= extent_x; rh_reg <= extent_y;
                end
            endcase
            ca_reg  <= {4'd0, extent_x};
            cb_reg  <= 12'sd0;
            da_reg  <= 12'sd1 - {3'd0, extent_x, 1'b0};
            db_reg  <= 12'sd0;
            err_reg <= 20'sd0;
            pt_reg  <= 3'd0;
            sx_reg  <= sx_next;
            sy_reg  <= sy_next;
            sn_reg  <= sn_next;
            rdb_reg <= 8'd0;
        end
        else
        begin
            rx_reg <= rx_next; ry_reg <= ry_next; rw_reg <= rw_next; rh_reg <= rh_next;
            ci_reg <= ci_next; cj_reg <= cj_next; part_reg <= part_next;
            ca_reg <= ca_next; cb_reg <= cb_next; da_reg <= da_next; db_reg <= db_next;
            err_reg <= err_next; pt_reg <= pt_next;
            sx_reg <= sx_next; sy_reg <= sy_next; sn_reg <= sn_next;
            rdb_reg <= rdb_next;
        end
    end

    mfsd_plotter #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_plotter (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (preq_mux),
        .rd_req   (accept && action == mfsd_pkg::ACT_READ),
        .busy     (p_busy),
        .clearing (p_clearing),
        .rd_data  (p_rd)
    );

    assign out_valid = (state_reg == S_RESP) && !p_clearing;
    assign read_byte = rdb_reg;

endmodule

// ----- sv/mfsd_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfsd_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module mfsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ----- sv/mfsd_plotter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfsd_plotter
// read-modify-write pixel unit over the byte store, plus clearing sweep
// ----------------------------------------------------------------------------
module mfsd_plotter #(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  mfsd_pkg::plot_req_t req,
    input  logic                rd_req,
    output logic                busy,
    output logic                clearing,
    output logic [7:0]          rd_data
);

    localparam int ROW_BYTES = (SCREEN_WIDTH + 7) / 8;
    localparam int DEPTH     = ROW_BYTES * SCREEN_HEIGHT;
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [3:0] {
        P_CLEAR = 4'b0001,
        P_IDLE  = 4'b0010,
        P_READ  = 4'b0100,
        P_WRITE = 4'b1000
    } pstate_t;

    pstate_t       state_reg, state_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [7:0]    mask_reg, mask_next;
    logic          color_reg, color_next;
    logic          on_screen;
    logic [AW-1:0] req_addr;
    logic          we;
    logic [7:0]    wdata, ram_q;

    assign on_screen = (32'(req.x) < SCREEN_WIDTH) && (32'(req.y) < SCREEN_HEIGHT);
    assign req_addr  = AW'(32'(req.y) * ROW_BYTES + 32'(req.x[7:3]));

    always_comb
    begin
        state_next = state_reg;
        addr_next  = addr_reg;
        mask_next  = mask_reg;
        color_next = color_reg;
        we         = 1'b0;
        wdata      = 8'd0;
        case (state_reg)
            P_CLEAR:
            begin
                we        = 1'b1;
                addr_next = addr_reg + AW'(1);
                if (32'(addr_reg) == DEPTH - 1)
                begin
                    state_next = P_IDLE;
                end
            end
            P_IDLE:
            begin
                if (req.valid && on_screen)
                begin
                    addr_next  = req_addr;
                    mask_next  = 8'h80 >> req.x[2:0];
                    color_next = req.color;
                    state_next = P_READ;
                end
                else if (rd_req)
                begin
                    addr_next = req_addr;
                end
            end
            P_READ:
            begin
                state_next = P_WRITE;
            end
            P_WRITE:
            begin
                we         = 1'b1;
                wdata      = color_reg ? (ram_q | mask_reg) : (ram_q & ~mask_reg);
                state_next = P_IDLE;
            end
            default:
            begin
                state_next = P_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= P_CLEAR;
            addr_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mask_reg  <= mask_next;
        color_reg <= color_next;
    end

    mfsd_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
        .clk   (clk),
        .we    (we),
        .addr  (addr_reg),
        .wdata (wdata),
        .rdata (ram_q)
    );

    assign busy     = (state_reg != P_IDLE);
    assign clearing = (state_reg == P_CLEAR);
    assign rd_data  = ram_q;

endmodule

// ----- dv/mono_framebuffer_shape_drawer_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mono_framebuffer_shape_drawer_core_tb
// drives drawing and read requests with random pacing and keeps a shadow
// frame buffer; every response is compared against the shadow's answer
// ----------------------------------------------------------------------------
module mono_framebuffer_shape_drawer_core_tb;

    localparam int WIDTH     = 128;
    localparam int HEIGHT    = 64;
    localparam int ROW_BYTES = (WIDTH + 7) / 8;
    localparam int N_RANDOM  = 680;

    // shadow frame buffer plus the queue of expected response bytes
    class frame_scoreboard;
        bit [7:0] shadow [ROW_BYTES*HEIGHT];
        bit [7:0] pending [$];
        int       errors;

        function new();
            foreach (shadow[i]) shadow[i] = '0;
            errors = 0;
        endfunction

        function void put_pixel(int px, int py, bit c);
            int ux;
            int uy;
            int idx;
            ux = px & 8'hFF;
            uy = py & 8'hFF;
            if (ux >= WIDTH || uy >= HEIGHT) return;
            idx = uy * ROW_BYTES + ux / 8;
            shadow[idx][7 - (ux % 8)] = c;
        endfunction

        function void fill(int x0, int y0, int w, int h, bit c);
            // size wraps mod 256, as the coordinates do
            w = w & 8'hFF;
            h = h & 8'hFF;
            for (int i = 0; i < w; i++)
                for (int j = 0; j < h; j++)
                    put_pixel(x0 + i, y0 + j, c);
        endfunction

        function void circle(int cx, int cy, int r, bit c, bit solid);
            int a;
            int b;
            int da;
            int db;
            int err;
            a = r; b = 0; da = 1 - 2 * r; db = 0; err = 0;
            while (a >= b)
            begin
                if (solid)
                begin
                    for (int i = cx - a; i <= cx + a; i++) put_pixel(i, cy + b, c);
                    for (int i = cx - a; i <= cx + a; i++) put_pixel(i, cy - b, c);
                    for (int i = cx - b; i <= cx + b; i++) put_pixel(i, cy + a, c);
                    for (int i = cx - b; i <= cx + b; i++) put_pixel(i, cy - a, c);
                end
                else
                begin
                    put_pixel(cx + a, cy + b, c); put_pixel(cx + b, cy + a, c);
                    put_pixel(cx - b, cy + a, c); put_pixel(cx - a, cy + b, c);
                    put_pixel(cx - a, cy - b, c); put_pixel(cx - b, cy - a, c);
                    put_pixel(cx + b, cy - a, c); put_pixel(cx + a, cy - b, c);
                end
                b++;
                err += db;
                db += 2;
                if (2 * err + da > 0)
                begin
                    a--;
                    err += da;
                    da += 2;
                end
            end
        endfunction

        // apply one accepted request and queue its response byte
        function void note_request(logic [2:0] act, int x, int y, int ex, int ey,
                                   int bw, bit c);
            bit [7:0] rsp;
            rsp = '0;
            case (act)
                mfsd_pkg::ACT_PIXEL: put_pixel(x, y, c);
                mfsd_pkg::ACT_RECT:  fill(x, y, ex, ey, c);
                mfsd_pkg::ACT_BOX:
                begin
                    fill(x, y, ex, bw, c);
                    fill(x, y + ey - bw, ex, bw, c);
                    fill(x, y, bw, ey, c);
                    fill(x + ex - bw, y, bw, ey, c);
                end
                mfsd_pkg::ACT_RING:  circle(x, y, ex, c, 1'b0);
                mfsd_pkg::ACT_DISC:  circle(x, y, ex, c, 1'b1);
                mfsd_pkg::ACT_READ:
                    if (x < WIDTH && y < HEIGHT) rsp = shadow[y * ROW_BYTES + x / 8];
                default: ;
            endcase
            pending.push_back(rsp);
        endfunction

        function void check_response(logic [7:0] got);
            bit [7:0] want;
            if (pending.size() == 0)
            begin
                $error("response with no request outstanding: read_byte=%0h", got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                $error("read_byte mismatch: expected %0h, actual %0h", want, got);
                errors++;
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [2:0] action;
    logic [7:0] pos_x;
    logic [7:0] pos_y;
    logic [7:0] extent_x;
    logic [7:0] extent_y;
    logic [7:0] border;
    logic       color;
    logic       out_valid;
    logic       out_ready;
    logic [7:0] read_byte;

    frame_scoreboard fb_model;
    int              burst_left;
    int              done_all;

    mono_framebuffer_shape_drawer_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .action   (action),
        .pos_x    (pos_x),
        .pos_y    (pos_y),
        .extent_x (extent_x),
        .extent_y (extent_y),
        .border   (border),
        .color    (color),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .read_byte(read_byte)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // monitor: note accepted requests and check responses at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                fb_model.note_request(action, int'(pos_x), int'(pos_y), int'(extent_x),
                                      int'(extent_y), int'(border), color);
            if (out_valid && out_ready)
                fb_model.check_response(read_byte);
        end
    end

    // receiver stall pattern: long ready runs broken by random stall stretches
    initial
    begin
        int phase;
        out_ready = 1'b0;
        phase = 0;
        forever
        begin
            @(negedge clk);
            phase++;
            if (phase % 200 < 60) out_ready <= 1'b1;          // stretch with no stalls
            else out_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // send one request; drive at the falling edge, return at the accepting edge
    task automatic send_request(logic [2:0] act, logic [7:0] x, logic [7:0] y,
                                logic [7:0] ex, logic [7:0] ey, logic [7:0] bw,
                                logic c);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 12);
            burst_left = $urandom_range(1, 8);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        action   <= act;
        pos_x    <= x;
        pos_y    <= y;
        extent_x <= ex;
        extent_y <= ey;
        border   <= bw;
        color    <= c;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // mostly small shapes so the run stays short; on-screen coordinates favored
    task automatic send_random();
        logic [2:0] act;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] ex;
        logic [7:0] ey;
        logic [7:0] bw;
        int         pick;
        pick = $urandom_range(0, 99);
        if (pick < 25) act = mfsd_pkg::ACT_READ;
        else if (pick < 45) act = mfsd_pkg::ACT_PIXEL;
        else if (pick < 58) act = mfsd_pkg::ACT_RECT;
        else if (pick < 71) act = mfsd_pkg::ACT_BOX;
        else if (pick < 82) act = mfsd_pkg::ACT_RING;
        else if (pick < 92) act = mfsd_pkg::ACT_DISC;
        else act = 3'($urandom_range(6, 7));
        x  = 8'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 135));
        y  = 8'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 70));
        ex = 8'(($urandom_range(0, 49) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 14));
        ey = 8'(($urandom_range(0, 49) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 14));
        bw = 8'(($urandom_range(0, 29) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 5));
        // circle cost grows quickly with radius; keep large radii rare
        if ((act == mfsd_pkg::ACT_RING || act == mfsd_pkg::ACT_DISC) && ex > 8'd20
            && $urandom_range(0, 3) != 0)
            ex = ex % 8'd16;
        send_request(act, x, y, ex, ey, bw, 1'($urandom_range(0, 1)));
    endtask

    // drop valid, then wait for every outstanding response
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (fb_model.pending.size() != 0) @(posedge clk);
    endtask

    initial
    begin
        fb_model   = new();
        burst_left = 0;
        done_all   = 0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        action     = mfsd_pkg::ACT_PIXEL;
        pos_x      = '0;
        pos_y      = '0;
        extent_x   = '0;
        extent_y   = '0;
        border     = '0;
        color      = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: corners, wraps, zero sizes, unused codes and reads back
        send_request(mfsd_pkg::ACT_READ,  8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   1'b0);
        send_request(mfsd_pkg::ACT_PIXEL, 8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   1'b1);
        send_request(mfsd_pkg::ACT_PIXEL, 8'd127, 8'd63,  8'd0,   8'd0,   8'd0,   1'b1);
        send_request(mfsd_pkg::ACT_PIXEL, 8'd255, 8'd255, 8'hFF,  8'hFF,  8'hFF,  1'b1);
        send_request(mfsd_pkg::ACT_READ,  8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   1'b0);
        send_request(mfsd_pkg::ACT_READ,  8'd127, 8'd63,  8'd0,   8'd0,   8'd0,   1'b0);
        send_request(mfsd_pkg::ACT_READ,  8'd200, 8'd10,  8'd0,   8'd0,   8'd0,   1'b0);
        send_request(mfsd_pkg::ACT_RECT,  8'd250, 8'd60,  8'd12,  8'd8,   8'd0,   1'b1);
        send_request(mfsd_pkg::ACT_RECT,  8'd10,  8'd10,  8'd0,   8'd5,   8'd0,   1'b1);
        send_request(mfsd_pkg::ACT_BOX,   8'd20,  8'd5,   8'd16,  8'd12,  8'd2,   1'b1);
        send_request(mfsd_pkg::ACT_BOX,   8'd40,  8'd20,  8'd6,   8'd4,   8'd9,   1'b1);
        send_request(mfsd_pkg::ACT_BOX,   8'd60,  8'd30,  8'd5,   8'd5,   8'd0,   1'b1);
        send_request(mfsd_pkg::ACT_RING,  8'd64,  8'd32,  8'd0,   8'd0,   8'd0,   1'b1);
        send_request(mfsd_pkg::ACT_RING,  8'd2,   8'd2,   8'd10,  8'd0,   8'd0,   1'b1);
        send_request(mfsd_pkg::ACT_DISC,  8'd120, 8'd60,  8'd6,   8'd0,   8'd0,   1'b1);
        send_request(mfsd_pkg::ACT_DISC,  8'd30,  8'd40,  8'd4,   8'd0,   8'd0,   1'b0);
        send_request(mfsd_pkg::ACT_RING,  8'd64,  8'd32,  8'd140, 8'd0,   8'd0,   1'b1);
        send_request(mfsd_pkg::ACT_RECT,  8'd0,   8'd0,   8'd255, 8'd1,   8'd0,   1'b0);
        send_request(3'd6,                8'd5,   8'd5,   8'd5,   8'd5,   8'd5,   1'b1);
        send_request(3'd7,                8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   1'b1);
        send_request(mfsd_pkg::ACT_READ,  8'd120, 8'd60,  8'd0,   8'd0,   8'd0,   1'b0);
        send_request(mfsd_pkg::ACT_READ,  8'd24,  8'd5,   8'd0,   8'd0,   8'd0,   1'b0);
        send_request(mfsd_pkg::ACT_READ,  8'd64,  8'd0,   8'd0,   8'd0,   8'd0,   1'b0);

        // hold off until every outstanding response has come back
        drain();

        for (int n = 0; n < N_RANDOM; n++)
        begin
            send_random();
            if (n == N_RANDOM / 2) drain();
        end

        drain();
        repeat (50) @(posedge clk);
        done_all = 1;
        if (fb_model.errors == 0 && fb_model.pending.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // watchdog: worst case assumes large shapes, slow receiver and wide gaps
    initial
    begin
        #400ms;
        if (!done_all)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

endmodule
